// File: rtl/crc_frx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_frx_pkg
// Shared constants, types and functions of the framed packet receiver.
// ----------------------------------------------------------------------------
package crc_frx_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_BYTES  = 32;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int POS_W       = $clog2(SLOT_BYTES);
    localparam int ADDR_W      = SLOT_W + POS_W;
    localparam int STORE_DEPTH = SLOTS * SLOT_BYTES;

    localparam int CFG_W = 5;
    localparam int LEN_W = 5;

    localparam logic [15:0]      CRC_POLY    = 16'h8408;
    localparam logic [15:0]      CRC_PRESET  = 16'hFFFF;
    localparam logic [15:0]      CRC_RESIDUE = 16'hF0B8;
    localparam logic [7:0]       CMD_MASK    = 8'hC0;
    localparam logic [LEN_W-1:0] LEN_CAP     = 5'd27;
    localparam logic [CFG_W-1:0] CFG_RESET   = 5'd19;

    // result status codes
    localparam logic [2:0] STS_ACCEPT   = 3'd0;
    localparam logic [2:0] STS_CRC_ERR  = 3'd1;
    localparam logic [2:0] STS_LEN_ERR  = 3'd2;
    localparam logic [2:0] STS_PKT_BYTE = 3'd3;
    localparam logic [2:0] STS_EMPTY    = 3'd4;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    // one byte of reflected CRC-16, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [LEN_W-1:0] len_limit(input logic [CFG_W-1:0] cfg);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(cfg);
        if (lim > LEN_CAP)
        begin
            lim = LEN_CAP;
        end
        if (int'(lim) > SLOT_BYTES - 2)
        begin
            lim = LEN_W'(SLOT_BYTES - 2);
        end
        return lim;
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (int'(s) == SLOTS - 1) ? '0 : s + SLOT_W'(1);
    endfunction

endpackage

// File: rtl/crc_framed_packet_receiver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver_core
// Framed link receiver with CRC-16/X.25 check and a ring of packet slots.
// ----------------------------------------------------------------------------
// A link byte (tuser[0] = 0) is handled in S_EXEC and the next transfer can
// follow at once; a byte that closes or aborts a frame, or a pop on an empty
// queue, waits while the output register still holds an untaken result. A pop
// on a stored packet of length L reads the length byte in S_EXEC, takes it and
// reads the command byte in S_POP_LEN, then streams L + 2 bytes in S_POP_DATA,
// paced by the single read port of the slot store and stalled while the output
// register stays untaken, and returns to S_IDLE after the last byte.
// No transfer is taken while a packet streams out.
// ----------------------------------------------------------------------------
module crc_framed_packet_receiver_core
    import crc_frx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,    // max_data_length
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]       s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] data_byte
    output logic             m_axis_tlast,
    output logic [3:0]       m_axis_tuser    // [2:0] status, [3] dropped_oldest
);

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_EXEC     = 2'd1;
    localparam logic [1:0] S_POP_LEN  = 2'd2;
    localparam logic [1:0] S_POP_DATA = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [CFG_W-1:0]  max_len_reg, max_len_next;
    logic [SLOT_W-1:0] ws_reg, ws_next;
    logic [SLOT_W-1:0] rs_reg, rs_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [15:0]       crc_reg, crc_next;
    logic [SLOTS-1:0]  unread_reg, unread_next;
    logic              op_reg, op_next;
    logic [7:0]        byte_reg, byte_next;
    logic [POS_W-1:0]  k_reg, k_next;
    logic [POS_W-1:0]  last_idx_reg, last_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_status_reg, out_status_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_drop_reg, out_drop_next;

    store_req_t        req;
    logic [7:0]        rd_data;

    logic              out_free;
    logic              exec_done;
    logic              emit;
    logic [2:0]        emit_status;
    logic [7:0]        emit_data;
    logic              emit_last;
    logic              emit_drop;
    logic [LEN_W-1:0]  limit;
    logic [15:0]       crc_upd;
    logic              body_end;
    logic [SLOT_W-1:0] ws_adv;
    logic [LEN_W-1:0]  rd_len;
    logic              in_xfer;

    crc_frx_store u_store
    (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign limit    = len_limit(max_len_reg);
    assign crc_upd  = crc_byte(crc_reg, byte_reg);
    assign body_end = ((LEN_W+1)'(fill_reg) + (LEN_W+1)'(1))
                      == ((LEN_W+1)'(len_reg) + (LEN_W+1)'(2));
    assign ws_adv   = next_slot(ws_reg);
    assign rd_len   = (rd_data > 8'(LEN_CAP)) ? LEN_CAP : rd_data[LEN_W-1:0];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        max_len_next    = max_len_reg;
        ws_next         = ws_reg;
        rs_next         = rs_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        unread_next     = unread_reg;
        op_next         = op_reg;
        byte_next       = byte_reg;
        k_next          = k_reg;
        last_idx_next   = last_idx_reg;
        req             = '0;
        exec_done       = 1'b0;
        emit            = 1'b0;
        emit_status     = STS_ACCEPT;
        emit_data       = 8'd0;
        emit_last       = 1'b1;
        emit_drop       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                if (op_reg)
                begin
                    if (unread_reg[rs_reg])
                    begin
                        req.rd_en   = 1'b1;
                        req.rd_addr = {rs_reg, POS_W'(1)};
                        state_next  = S_POP_LEN;
                    end
                    else if (out_free)
                    begin
                        emit        = 1'b1;
                        emit_status = STS_EMPTY;
                        exec_done   = 1'b1;
                    end
                end
                else
                begin
                    unique case (phase_reg)
                        PH_LEN:
                        begin
                            if (byte_reg > 8'(limit))
                            begin
                                // abort the frame
                                if (out_free)
                                begin
                                    emit        = 1'b1;
                                    emit_status = STS_LEN_ERR;
                                    phase_next  = PH_CMD;
                                    exec_done   = 1'b1;
                                end
                            end
                            else
                            begin
                                req.wr_en   = 1'b1;
                                req.wr_addr = {ws_reg, POS_W'(1)};
                                req.wr_data = byte_reg;
                                len_next    = byte_reg[LEN_W-1:0];
                                crc_next    = crc_upd;
                                fill_next   = '0;
                                phase_next  = PH_BODY;
                                exec_done   = 1'b1;
                            end
                        end
                        PH_BODY:
                        begin
                            if (!body_end || out_free)
                            begin
                                exec_done = 1'b1;
                                crc_next  = crc_upd;
                                fill_next = fill_reg + LEN_W'(1);
                                if (fill_reg < len_reg)
                                begin
                                    req.wr_en   = 1'b1;
                                    req.wr_addr = {ws_reg, POS_W'(fill_reg) + POS_W'(2)};
                                    req.wr_data = byte_reg;
                                end
                                if (body_end)
                                begin
                                    phase_next = PH_CMD;
                                    emit       = 1'b1;
                                    if (crc_upd != CRC_RESIDUE)
                                    begin
                                        emit_status = STS_CRC_ERR;
                                    end
                                    else
                                    begin
                                        emit_status         = STS_ACCEPT;
                                        unread_next[ws_reg] = 1'b1;
                                        ws_next             = ws_adv;
                                        // ring full: drop the oldest unread packet
                                        if (ws_adv == rs_reg)
                                        begin
                                            unread_next[rs_reg] = 1'b0;
                                            rs_next             = next_slot(rs_reg);
                                            emit_drop           = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            // waiting for a command byte; skip anything else
                            exec_done  = 1'b1;
                            phase_next = PH_CMD;
                            if ((byte_reg & CMD_MASK) != 8'd0)
                            begin
                                req.wr_en   = 1'b1;
                                req.wr_addr = {ws_reg, POS_W'(0)};
                                req.wr_data = byte_reg;
                                crc_next    = crc_byte(CRC_PRESET, byte_reg);
                                fill_next   = '0;
                                phase_next  = PH_LEN;
                            end
                        end
                    endcase
                end
            end
            S_POP_LEN:
            begin
                last_idx_next = POS_W'(rd_len) + POS_W'(1);
                k_next        = '0;
                req.rd_en     = 1'b1;
                req.rd_addr   = {rs_reg, POS_W'(0)};
                state_next    = S_POP_DATA;
            end
            S_POP_DATA:
            begin
                // read data holds until the next read is issued
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_status = STS_PKT_BYTE;
                    emit_data   = rd_data;
                    emit_last   = (k_reg == last_idx_reg);
                    if (k_reg == last_idx_reg)
                    begin
                        unread_next[rs_reg] = 1'b0;
                        rs_next             = next_slot(rs_reg);
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        k_next      = k_reg + POS_W'(1);
                        req.rd_en   = 1'b1;
                        req.rd_addr = {rs_reg, k_reg + POS_W'(1)};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        s_axis_tready = (state_reg == S_IDLE) || ((state_reg == S_EXEC) && exec_done);

        if (in_xfer)
        begin
            op_next    = s_axis_tuser[0];
            byte_next  = s_axis_tdata;
            state_next = S_EXEC;
        end
        else if ((state_reg == S_EXEC) && exec_done)
        begin
            state_next = S_IDLE;
        end

        if (cfg_wr_en)
        begin
            max_len_next = cfg_wr_data;
        end

        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_drop_next   = out_drop_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = emit_status;
            out_data_next   = emit_data;
            out_last_next   = emit_last;
            out_drop_next   = emit_drop;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_CMD;
            max_len_reg   <= CFG_RESET;
            ws_reg        <= '0;
            rs_reg        <= '0;
            fill_reg      <= '0;
            crc_reg       <= CRC_PRESET;
            unread_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            max_len_reg   <= max_len_next;
            ws_reg        <= ws_next;
            rs_reg        <= rs_next;
            fill_reg      <= fill_next;
            crc_reg       <= crc_next;
            unread_reg    <= unread_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        op_reg         <= op_next;
        byte_reg       <= byte_next;
        k_reg          <= k_next;
        last_idx_reg   <= last_idx_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
        out_drop_reg   <= out_drop_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_drop_reg, out_status_reg};

endmodule

// File: rtl/crc_frx_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_frx_store
// Packet slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crc_frx_store
    import crc_frx_pkg::*;
(
    input  logic       clk,
    input  store_req_t req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed packet receiver. Link bytes and pop
// requests are fed from a queue by a clocked driver. A behavioural copy of the
// parser, CRC and slot ring forecasts every report, and a clocked monitor
// compares each output transfer with the oldest forecast.
// ----------------------------------------------------------------------------
module tb_top;
    import crc_frx_pkg::*;

    localparam logic OP_LINK       = 1'b0;
    localparam logic OP_POP        = 1'b1;
    localparam int   SETTLE_CYCLES = 4;
    localparam int   TAIL_CYCLES   = 40;
    localparam int   STALL_LIMIT   = 5000;
    localparam int   PHASE_ITEMS   = 62;
    localparam int   LONG_HOLD     = 300;

    typedef enum logic [1:0] {PH_COMMAND, PH_LENGTH, PH_BODY} parse_phase_t;
    typedef enum logic [1:0] {ENT_TRANSFER, ENT_DRAIN, ENT_CONFIG} entry_kind_t;

    typedef struct packed {
        entry_kind_t      kind;
        logic             op;
        logic [7:0]       rx_byte;
        logic [CFG_W-1:0] cfg;
    } link_entry_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic       last;
        logic       dropped_oldest;
    } rx_report_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = '0;
    logic [0:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;
    logic             m_axis_tlast;
    logic [3:0]       m_axis_tuser;

    crc_framed_packet_receiver_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver state as the bench sees it
    logic [CFG_W-1:0]  max_len_cfg = CFG_RESET;
    parse_phase_t      phase = PH_COMMAND;
    logic [SLOT_W-1:0] wr_slot = '0;
    logic [SLOT_W-1:0] rd_slot = '0;
    logic [4:0]        body_count = '0;
    logic [15:0]       crc_acc = CRC_PRESET;
    logic [7:0]        slot_mem [STORE_DEPTH];
    logic [SLOTS-1:0]  unread = '0;

    rx_report_t  reports_due [$];
    link_entry_t link_queue [$];
    logic [7:0]  frame_body [$];

    bit link_fire = 1'b0;
    int failures = 0;
    int idle_cycles = 0;
    int link_xfers = 0;
    int planned_items = 0;
    int send_gap = 0;
    int send_burst = 0;
    int settle_count = 0;

    function automatic logic [15:0] x25_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic int length_limit(input logic [CFG_W-1:0] cfg);
        int lim;
        lim = int'(cfg);
        if (lim > int'(LEN_CAP))
        begin
            lim = int'(LEN_CAP);
        end
        if (lim > SLOT_BYTES - 2)
        begin
            lim = SLOT_BYTES - 2;
        end
        return lim;
    endfunction

    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
        return (int'(s) + 1 >= SLOTS) ? '0 : SLOT_W'(int'(s) + 1);
    endfunction

    task automatic push_report(input logic [2:0] st, input logic [7:0] d, input logic lst,
                               input logic drop);
        rx_report_t rep;
        rep.status = st;
        rep.data_byte = d;
        rep.last = lst;
        rep.dropped_oldest = drop;
        reports_due.push_back(rep);
    endtask

    // forecast the reports caused by one accepted input transfer
    task automatic advance_receiver(input logic op, input logic [7:0] b);
        int base_w;
        int base_r;
        int len;
        int n;
        logic drop;
        base_w = int'(wr_slot) * SLOT_BYTES;
        base_r = int'(rd_slot) * SLOT_BYTES;
        if (op == OP_POP)
        begin
            if (!unread[rd_slot])
            begin
                push_report(STS_EMPTY, 8'h00, 1'b1, 1'b0);
            end
            else
            begin
                len = int'(slot_mem[base_r + 1]);
                if (len > int'(LEN_CAP))
                begin
                    len = int'(LEN_CAP);
                end
                n = len + 2;
                for (int k = 0; k < n; k++)
                begin
                    push_report(STS_PKT_BYTE, slot_mem[base_r + k], k == n - 1, 1'b0);
                end
                unread[rd_slot] = 1'b0;
                rd_slot = ring_next(rd_slot);
            end
        end
        else
        begin
            case (phase)
                PH_LENGTH:
                begin
                    if (int'(b) > length_limit(max_len_cfg))
                    begin
                        phase = PH_COMMAND;
                        push_report(STS_LEN_ERR, 8'h00, 1'b1, 1'b0);
                    end
                    else
                    begin
                        slot_mem[base_w + 1] = b;
                        crc_acc = x25_update(crc_acc, b);
                        body_count = '0;
                        phase = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    len = int'(slot_mem[base_w + 1]);
                    crc_acc = x25_update(crc_acc, b);
                    if (int'(body_count) < len)
                    begin
                        slot_mem[base_w + 2 + int'(body_count)] = b;
                    end
                    body_count = body_count + 5'd1;
                    if (int'(body_count) >= len + 2)
                    begin
                        phase = PH_COMMAND;
                        if (crc_acc != CRC_RESIDUE)
                        begin
                            push_report(STS_CRC_ERR, 8'h00, 1'b1, 1'b0);
                        end
                        else
                        begin
                            drop = 1'b0;
                            unread[wr_slot] = 1'b1;
                            wr_slot = ring_next(wr_slot);
                            // ring full: the oldest unread packet gives way
                            if (wr_slot == rd_slot)
                            begin
                                unread[rd_slot] = 1'b0;
                                rd_slot = ring_next(rd_slot);
                                drop = 1'b1;
                            end
                            push_report(STS_ACCEPT, 8'h00, 1'b1, drop);
                        end
                    end
                end
                default:
                begin
                    phase = PH_COMMAND;
                    if ((b & CMD_MASK) != 8'h00)
                    begin
                        slot_mem[base_w] = b;
                        crc_acc = x25_update(CRC_PRESET, b);
                        body_count = '0;
                        phase = PH_LENGTH;
                    end
                end
            endcase
        end
    endtask

    task automatic push_transfer(input logic op, input logic [7:0] b);
        link_entry_t e;
        e.kind = ENT_TRANSFER;
        e.op = op;
        e.rx_byte = b;
        e.cfg = '0;
        link_queue.push_back(e);
    endtask

    task automatic push_control(input entry_kind_t kind, input logic [CFG_W-1:0] v);
        link_entry_t e;
        e.kind = kind;
        e.op = OP_LINK;
        e.rx_byte = 8'h00;
        e.cfg = v;
        link_queue.push_back(e);
    endtask

    // frame from frame_body: command, length, body, inverted CRC low byte first; optionally corrupted, pop at pop_at
    task automatic add_frame(input logic [7:0] cmd, input bit corrupt, input int pop_at);
        logic [7:0] wire_bytes [$];
        logic [15:0] crc;
        int idx;
        wire_bytes.push_back(cmd);
        wire_bytes.push_back(8'(frame_body.size()));
        foreach (frame_body[i])
        begin
            wire_bytes.push_back(frame_body[i]);
        end
        crc = CRC_PRESET;
        foreach (wire_bytes[i])
        begin
            crc = x25_update(crc, wire_bytes[i]);
        end
        crc = ~crc;
        wire_bytes.push_back(crc[7:0]);
        wire_bytes.push_back(crc[15:8]);
        if (corrupt)
        begin
            idx = wire_bytes.size() - 1 - $urandom_range(0, 1);
            wire_bytes[idx] = wire_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        foreach (wire_bytes[i])
        begin
            if (i == pop_at)
            begin
                push_transfer(OP_POP, 8'($urandom_range(0, 255)));
                planned_items++;
            end
            push_transfer(OP_LINK, wire_bytes[i]);
        end
        planned_items += wire_bytes.size();
    endtask

    task automatic add_random_unit(input int lim);
        int r;
        int len;
        int pop_at;
        logic [7:0] cmd;
        r = $urandom_range(0, 99);
        cmd = 8'($urandom_range(64, 255));
        if (r < 18)
        begin
            push_transfer(OP_POP, 8'($urandom_range(0, 255)));
            planned_items++;
        end
        else if (r < 22)
        begin
            repeat ($urandom_range(1, 3))
            begin
                push_transfer(OP_LINK, 8'($urandom_range(0, 63)));
            end
        end
        else if (r < 24)
        begin
            push_control(ENT_DRAIN, '0);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                len = lim;
            end
            else if (r < 11)
            begin
                len = lim + 1;
            end
            else if (r < 14)
            begin
                len = $urandom_range(lim + 1, 255);
            end
            else
            begin
                len = $urandom_range(0, (lim < 4) ? lim : 4);
            end
            if (len > lim)
            begin
                push_transfer(OP_LINK, cmd);
                push_transfer(OP_LINK, 8'(len));
                planned_items += 2;
            end
            else
            begin
                frame_body.delete();
                repeat (len)
                begin
                    frame_body.push_back(8'($urandom_range(0, 255)));
                end
                pop_at = ($urandom_range(0, 14) == 0) ? $urandom_range(1, len + 3) : -1;
                add_frame(cmd, $urandom_range(0, 99) < 15, pop_at);
            end
        end
    endtask

    function automatic int next_send_gap();
        int r;
        if (send_burst > 0)
        begin
            send_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            send_burst = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // sender: hold each transfer until taken, configure only when the block is idle
    always @(negedge clk)
    begin
        link_entry_t head;
        logic valid_next;
        logic wr_pulse;
        valid_next = s_axis_tvalid && !link_fire;
        wr_pulse = 1'b0;
        if (rst_n && !valid_next)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (link_queue.size() > 0)
            begin
                head = link_queue[0];
                if (head.kind == ENT_TRANSFER)
                begin
                    void'(link_queue.pop_front());
                    s_axis_tdata <= head.rx_byte;
                    s_axis_tuser <= head.op;
                    valid_next = 1'b1;
                    send_gap = next_send_gap();
                end
                else if (reports_due.size() == 0 && !m_axis_tvalid)
                begin
                    if (settle_count < SETTLE_CYCLES)
                    begin
                        settle_count++;
                    end
                    else
                    begin
                        settle_count = 0;
                        void'(link_queue.pop_front());
                        if (head.kind == ENT_CONFIG)
                        begin
                            wr_pulse = 1'b1;
                            cfg_wr_data <= head.cfg;
                        end
                    end
                end
                else
                begin
                    settle_count = 0;
                end
            end
        end
        s_axis_tvalid <= valid_next;
        cfg_wr_en <= wr_pulse;
    end

    // receiver back-pressure, with one long hold-off while the sender keeps going
    int  hold_left = 0;
    int  ready_burst = 0;
    bit  long_hold_done = 1'b0;

    always @(negedge clk)
    begin
        int r;
        logic ready_next;
        ready_next = 1'b0;
        if (hold_left > 0)
        begin
            hold_left--;
        end
        else if (!long_hold_done && link_xfers >= 100)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        else if (ready_burst > 0)
        begin
            ready_burst--;
            ready_next = 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                ready_burst = $urandom_range(20, 60);
                ready_next = 1'b1;
            end
            else if (r < 6)
            begin
                hold_left = $urandom_range(5, 40);
            end
            else
            begin
                ready_next = (r >= 30);
            end
        end
        m_axis_tready <= rst_n && ready_next;
    end

    always @(posedge clk)
    begin
        rx_report_t want;
        bit out_fire;
        link_fire = rst_n && s_axis_tvalid && s_axis_tready;
        out_fire = rst_n && m_axis_tvalid && m_axis_tready;
        if (rst_n && cfg_wr_en)
        begin
            max_len_cfg = cfg_wr_data;
        end
        if (link_fire)
        begin
            advance_receiver(s_axis_tuser[0], s_axis_tdata);
            link_xfers++;
        end
        if (out_fire)
        begin
            if (reports_due.size() == 0)
            begin
                $error("unexpected result: status %0d data %02h last %0b",
                       m_axis_tuser[2:0], m_axis_tdata, m_axis_tlast);
                failures++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (m_axis_tuser[2:0] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:0]);
                    failures++;
                end
                if (m_axis_tdata !== want.data_byte)
                begin
                    $error("data_byte: expected %02h, got %02h", want.data_byte, m_axis_tdata);
                    failures++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
                    failures++;
                end
                if (m_axis_tuser[3] !== want.dropped_oldest)
                begin
                    $error("dropped_oldest: expected %0b, got %0b", want.dropped_oldest,
                           m_axis_tuser[3]);
                    failures++;
                end
            end
        end
        if (link_fire || out_fire || cfg_wr_en)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0] phase_cfg [4];
        int target;
        phase_cfg[0] = 5'd27;
        phase_cfg[1] = 5'd0;
        phase_cfg[2] = 5'd31;
        phase_cfg[3] = CFG_W'($urandom_range(1, 26));

        // directed opening at the reset limit
        push_transfer(OP_POP, 8'h00);
        push_transfer(OP_LINK, 8'h00);
        push_transfer(OP_LINK, 8'h3F);
        frame_body.delete();
        add_frame(8'hFF, 1'b0, -1);
        push_transfer(OP_POP, 8'hFF);
        push_transfer(OP_LINK, 8'h80);
        push_transfer(OP_LINK, 8'd20);
        push_transfer(OP_LINK, 8'hC1);
        push_transfer(OP_LINK, 8'hFF);
        frame_body.push_back(8'hAA);
        add_frame(8'h41, 1'b1, -1);
        frame_body.delete();
        frame_body.push_back(8'h00);
        frame_body.push_back(8'hFF);
        add_frame(8'hC0, 1'b0, 3);
        push_transfer(OP_POP, 8'h00);
        push_control(ENT_DRAIN, '0);

        planned_items = 26;
        for (int p = 0; p < 4; p++)
        begin
            push_control(ENT_CONFIG, phase_cfg[p]);
            target = planned_items + PHASE_ITEMS;
            while (planned_items < target)
            begin
                add_random_unit(length_limit(phase_cfg[p]));
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (link_queue.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (reports_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0 && reports_due.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
